// ===== hw/rtl/complex_fixed_point_alu_defines.svh =====
// Assertion helpers for the top RTL file of the complex ALU.
`ifndef COMPLEX_FIXED_POINT_ALU_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CFPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CFPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cfpa_pkg.sv =====
`timescale 1ns / 1ps

package cfpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_EXP   = 16;
  localparam int EXP_BITS  = 6;
  localparam int OP_BITS   = 3;
  localparam int ST_BITS   = 2;

  localparam int ACC_W  = 2 * WORD_BITS + 1;
  localparam int DEN_W  = 2 * WORD_BITS;
  localparam int NUM_W  = 2 * WORD_BITS + FRAC_BITS;
  localparam int ROOT_W = WORD_BITS;
  localparam int REM_W  = WORD_BITS + 2;
  localparam int CNT_W  = $clog2(MAX_EXP + 1);

  localparam logic signed [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_MOD = 3'd5
  } opcode_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_POST,
    S_DIVRE,
    S_DIVIM,
    S_SQRT,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MAC_MUL,
    MAC_DIVN,
    MAC_SQ
  } mac_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hw/rtl/cfpa_mul.sv =====
`timescale 1ns / 1ps

module cfpa_mul import cfpa_pkg::*; (
  input  logic                          clk_i,
  input  logic signed [WORD_BITS-1:0]   a_i,
  input  logic signed [WORD_BITS-1:0]   b_i,
  output logic signed [2*WORD_BITS-1:0] p_o
);

  logic signed [2*WORD_BITS-1:0] p_q;

  // Product is registered so the accumulate sits in the following cycle.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/cfpa_div.sv =====
`timescale 1ns / 1ps

module cfpa_div import cfpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output unit_stat_t       stat_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int DCNT_W = $clog2(NUM_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  n_q, n_d;
  logic [DEN_W-1:0]  d_q, d_d, r_q, r_d;
  logic [DEN_W:0]    r_sh, diff;
  logic              ge;

  // One quotient bit per cycle, restoring form; the dividend shifts out
  // at the top while quotient bits shift in at the bottom.
  assign r_sh = {r_q, n_q[NUM_W-1]};
  assign diff = r_sh - {1'b0, d_q};
  assign ge   = (r_sh >= {1'b0, d_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    d_d    = d_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(NUM_W - 1);
      n_d    = dividend_i;
      d_d    = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = ge ? diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
      n_d   = {n_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
    r_q <= r_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = n_q;

endmodule

// ===== hw/rtl/cfpa_sqrt.sv =====
`timescale 1ns / 1ps

module cfpa_sqrt import cfpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEN_W-1:0]  rad_i,
  output unit_stat_t        stat_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [REM_W-1:0]  rem_o
);

  localparam int SCNT_W = $clog2(ROOT_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [SCNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W+1:0]  rem_sh, trial, diff;
  logic              ge;

  // Two radicand bits enter per cycle and one root bit is settled.
  assign rem_sh = {rem_q, rad_q[DEN_W-1:DEN_W-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = SCNT_W'(ROOT_W - 1);
      rad_d  = rad_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      rad_d  = {rad_q[DEN_W-3:0], 2'b00};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/complex_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// Complex fixed-point ALU on signed Q16.16 operands.
// Input channel: one beat carries opcode, both complex operands and an
// exponent; it is taken when in_valid_i and in_ready_o are both high.
// Output channel: one beat per input beat with the real part, the
// imaginary part and a status code (ok, divide by zero, overflow).
// The block works on one beat at a time and holds in_ready_o low while
// busy. Add, subtract, unused opcodes and a power with exponent zero go
// straight to the final state. Multiply runs one multiply-accumulate pass;
// modulus a pass and a square root, one bit per cycle; divide a pass for
// the denominator, one for the numerators, then two 80-bit divisions; a
// zero divisor ends after the denominator pass. Power runs one pass per
// multiplication step, and a negative exponent adds a division. A new beat
// is taken only after the previous result is written to the output
// register. The single shared 32x32 multiplier and the bit-serial divider
// and square-root units set how long each operation takes.
// A finished result sits in the output register until taken; if the
// receiver stalls, the next beat can still be accepted and computed, and
// the block waits in its final state until the output register is free.
// Reset clears the sequencer and the output valid; no result is pending.
module complex_fixed_point_alu import cfpa_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [OP_BITS-1:0]          opcode_i,
  input  logic signed [WORD_BITS-1:0] a_real_i,
  input  logic signed [WORD_BITS-1:0] a_imag_i,
  input  logic signed [WORD_BITS-1:0] b_real_i,
  input  logic signed [WORD_BITS-1:0] b_imag_i,
  input  logic signed [EXP_BITS-1:0]  exponent_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] res_real_o,
  output logic signed [WORD_BITS-1:0] res_imag_o,
  output logic [ST_BITS-1:0]          status_o
);

  `include "complex_fixed_point_alu_defines.svh"

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 ov;
  } sat_t;

  // Round half up at the Q16.16 point, then clamp to the word range.
  function automatic sat_t rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    sat_t r;
    t = (v + ACC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    r.val = t[WORD_BITS-1:0];
    r.ov  = 1'b0;
    if (t[ACC_W-1] && !(&t[ACC_W-1:WORD_BITS-1])) begin
      r.val = WMIN;
      r.ov  = 1'b1;
    end else if (!t[ACC_W-1] && (|t[ACC_W-1:WORD_BITS-1])) begin
      r.val = WMAX;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

  // Clamp a one-bit-grown sum to the word range.
  function automatic sat_t sum_sat(input logic signed [WORD_BITS:0] s);
    sat_t r;
    r.val = s[WORD_BITS-1:0];
    r.ov  = 1'b0;
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r.val = s[WORD_BITS] ? WMIN : WMAX;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

  // Restore the sign of a quotient magnitude and clamp it.
  function automatic sat_t quot_sat(input logic [NUM_W-1:0] q, input logic neg);
    sat_t r;
    r.ov = 1'b0;
    if (neg) begin
      r.val = WORD_BITS'(~q[WORD_BITS-1:0] + 1'b1);
      if ((|q[NUM_W-1:WORD_BITS]) || (q[WORD_BITS-1] && (|q[WORD_BITS-2:0]))) begin
        r.val = WMIN;
        r.ov  = 1'b1;
      end
    end else begin
      r.val = q[WORD_BITS-1:0];
      if (|q[NUM_W-1:WORD_BITS-1]) begin
        r.val = WMAX;
        r.ov  = 1'b1;
      end
    end
    return r;
  endfunction

  state_e                  state_q, state_d;
  opcode_e                 op_q, op_d;
  mac_e                    mac_q, mac_d;
  logic [2:0]              step_q, step_d;
  logic [WORD_BITS-1:0]    xr_q, xr_d, xi_q, xi_d, yr_q, yr_d, yi_q, yi_d;
  logic signed [ACC_W-1:0] acc0_q, acc0_d, acc1_q, acc1_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    eneg_q, eneg_d, ov_q, ov_d, dz_q, dz_d;
  logic [WORD_BITS-1:0]    rr_q, rr_d, ri_q, ri_d;
  logic                    out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]    out_re_q, out_re_d, out_im_q, out_im_d;
  status_e                 out_st_q, out_st_d;

  logic signed [WORD_BITS-1:0]   mul_a, mul_b;
  logic signed [2*WORD_BITS-1:0] prod;
  logic                          pair_sub;
  logic signed [ACC_W-1:0]       prod_ext;
  logic                          in_fire, out_free;

  logic             div_start, sqrt_start;
  logic [NUM_W-1:0] div_num, quot;
  logic             neg_q, neg_d;
  logic [DEN_W-1:0] div_den;
  unit_stat_t       div_stat, sqrt_stat;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;

  sat_t                  rnd_re, rnd_im, q_res, add_re, add_im;
  logic [WORD_BITS:0]    root_inc;
  logic [EXP_BITS:0]     exp_mag;
  logic [CNT_W-1:0]      exp_cnt;
  logic signed [ACC_W-1:0] div_acc;
  logic [DEN_W-1:0]      div_mag;
  logic                  post_last_pow;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Operand pairs of the multiply-accumulate pass. Pairs 0 and 1 land in
  // acc0, pairs 2 and 3 in acc1.
  always_comb begin
    mul_a    = xr_q;
    mul_b    = yr_q;
    pair_sub = 1'b0;
    case (mac_q)
      MAC_MUL: begin
        case (step_q[1:0])
          2'd0: begin mul_a = xr_q; mul_b = yr_q; end
          2'd1: begin mul_a = xi_q; mul_b = yi_q; end
          2'd2: begin mul_a = xr_q; mul_b = yi_q; end
          default: begin mul_a = xi_q; mul_b = yr_q; end
        endcase
      end
      MAC_DIVN: begin
        case (step_q[1:0])
          2'd0: begin mul_a = xr_q; mul_b = yr_q; end
          2'd1: begin mul_a = xi_q; mul_b = yi_q; end
          2'd2: begin mul_a = xi_q; mul_b = yr_q; end
          default: begin mul_a = xr_q; mul_b = yi_q; end
        endcase
      end
      default: begin
        mul_a = (step_q[1:0] == 2'd1) ? yi_q : yr_q;
        mul_b = mul_a;
      end
    endcase
    // The product arriving now belongs to the previous step.
    case (mac_q)
      MAC_MUL:  pair_sub = (step_q == 3'd2);
      MAC_DIVN: pair_sub = (step_q == 3'd4);
      default:  pair_sub = 1'b0;
    endcase
  end

  cfpa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_ext = {prod[2*WORD_BITS-1], prod};

  cfpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  cfpa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc0_q[DEN_W-1:0]),
    .stat_o  (sqrt_stat),
    .root_o  (root),
    .rem_o   (rem)
  );

  assign rnd_re = rnd_sat(acc0_q);
  assign rnd_im = rnd_sat(acc1_q);
  assign q_res  = quot_sat(quot, neg_q);
  assign add_re = (opcode_e'(opcode_i) == OP_SUB) ?
                  sum_sat({a_real_i[WORD_BITS-1], a_real_i} - {b_real_i[WORD_BITS-1], b_real_i}) :
                  sum_sat({a_real_i[WORD_BITS-1], a_real_i} + {b_real_i[WORD_BITS-1], b_real_i});
  assign add_im = (opcode_e'(opcode_i) == OP_SUB) ?
                  sum_sat({a_imag_i[WORD_BITS-1], a_imag_i} - {b_imag_i[WORD_BITS-1], b_imag_i}) :
                  sum_sat({a_imag_i[WORD_BITS-1], a_imag_i} + {b_imag_i[WORD_BITS-1], b_imag_i});

  // Square root is rounded to nearest: step up when the remainder exceeds s.
  assign root_inc = {1'b0, root} + {{WORD_BITS{1'b0}}, (rem > {2'b00, root})};

  assign exp_mag = exponent_i[EXP_BITS-1] ? (EXP_BITS+1)'(-{exponent_i[EXP_BITS-1], exponent_i})
                                          : {1'b0, exponent_i};
  assign exp_cnt = (exp_mag > (EXP_BITS+1)'(MAX_EXP)) ? CNT_W'(MAX_EXP) : exp_mag[CNT_W-1:0];

  // Division operand: |n| scaled by the fraction plus half the divisor.
  assign div_acc = (state_q == S_POST) ? acc0_q : acc1_q;
  assign div_mag = div_acc[ACC_W-1] ? DEN_W'(-div_acc) : div_acc[DEN_W-1:0];
  assign div_num = {div_mag, {FRAC_BITS{1'b0}}} + NUM_W'(den_q >> 1);
  assign div_den = den_q;

  assign post_last_pow = (cnt_q == CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OP_MUL, OP_DIV, OP_MOD: state_d = S_MAC;
            OP_POW:  state_d = (exp_cnt == '0) ? S_FIN : S_MAC;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_MAC: begin
        if (step_q == 3'd4) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        case (mac_q)
          MAC_SQ: begin
            if (op_q == OP_MOD) begin
              state_d = S_SQRT;
            end else begin
              state_d = (acc0_q == '0) ? S_FIN : S_MAC;
            end
          end
          MAC_DIVN: state_d = S_DIVRE;
          default: begin
            if (op_q == OP_POW && (!post_last_pow || eneg_q)) begin
              state_d = S_MAC;
            end else begin
              state_d = S_FIN;
            end
          end
        endcase
      end
      S_DIVRE: if (div_stat.done) state_d = S_DIVIM;
      S_DIVIM: if (div_stat.done) state_d = S_FIN;
      S_SQRT:  if (sqrt_stat.done) state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and unit control.
  always_comb begin
    op_d        = op_q;
    mac_d       = mac_q;
    step_d      = step_q;
    xr_d        = xr_q;
    xi_d        = xi_q;
    yr_d        = yr_q;
    yi_d        = yi_q;
    acc0_d      = acc0_q;
    acc1_d      = acc1_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    eneg_d      = eneg_q;
    ov_d        = ov_q;
    dz_d        = dz_q;
    rr_d        = rr_q;
    ri_d        = ri_q;
    neg_d       = neg_q;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_re_d    = out_re_q;
    out_im_d    = out_im_q;
    out_st_d    = out_st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = opcode_e'(opcode_i);
          step_d = '0;
          xr_d   = a_real_i;
          xi_d   = a_imag_i;
          yr_d   = b_real_i;
          yi_d   = b_imag_i;
          cnt_d  = exp_cnt;
          eneg_d = exponent_i[EXP_BITS-1];
          ov_d   = 1'b0;
          dz_d   = 1'b0;
          rr_d   = '0;
          ri_d   = '0;
          mac_d  = MAC_MUL;
          case (opcode_e'(opcode_i))
            OP_ADD, OP_SUB: begin
              rr_d = add_re.val;
              ri_d = add_im.val;
              ov_d = add_re.ov | add_im.ov;
            end
            OP_DIV: mac_d = MAC_SQ;
            OP_MOD: begin
              mac_d = MAC_SQ;
              yr_d  = a_real_i;
              yi_d  = a_imag_i;
            end
            OP_POW: begin
              xr_d = ONE_Q;
              xi_d = '0;
              yr_d = a_real_i;
              yi_d = a_imag_i;
              rr_d = ONE_Q;
            end
            default: begin
              rr_d = '0;
            end
          endcase
        end
      end
      S_MAC: begin
        step_d = step_q + 1'b1;
        if (step_q == 3'd0) begin
          acc0_d = '0;
          acc1_d = '0;
        end else if (step_q <= 3'd2) begin
          acc0_d = pair_sub ? acc0_q - prod_ext : acc0_q + prod_ext;
        end else begin
          acc1_d = pair_sub ? acc1_q - prod_ext : acc1_q + prod_ext;
        end
      end
      S_POST: begin
        step_d = '0;
        case (mac_q)
          MAC_SQ: begin
            if (op_q == OP_MOD) begin
              sqrt_start = 1'b1;
            end else begin
              den_d = acc0_q[DEN_W-1:0];
              mac_d = MAC_DIVN;
              if (acc0_q == '0) begin
                dz_d = 1'b1;
                rr_d = '0;
                ri_d = '0;
              end
            end
          end
          MAC_DIVN: begin
            div_start = 1'b1;
            neg_d     = acc0_q[ACC_W-1];
          end
          default: begin
            ov_d = ov_q | rnd_re.ov | rnd_im.ov;
            rr_d = rnd_re.val;
            ri_d = rnd_im.val;
            if (op_q == OP_POW) begin
              xr_d  = rnd_re.val;
              xi_d  = rnd_im.val;
              cnt_d = cnt_q - 1'b1;
              if (post_last_pow && eneg_q) begin
                yr_d  = rnd_re.val;
                yi_d  = rnd_im.val;
                xr_d  = ONE_Q;
                xi_d  = '0;
                mac_d = MAC_SQ;
              end
            end
          end
        endcase
      end
      S_DIVRE: begin
        if (div_stat.done) begin
          rr_d      = q_res.val;
          ov_d      = ov_q | q_res.ov;
          div_start = 1'b1;
          neg_d     = acc1_q[ACC_W-1];
        end
      end
      S_DIVIM: begin
        if (div_stat.done) begin
          ri_d = q_res.val;
          ov_d = ov_q | q_res.ov;
        end
      end
      S_SQRT: begin
        if (sqrt_stat.done) begin
          ri_d = '0;
          if (root_inc[WORD_BITS] || root_inc[WORD_BITS-1]) begin
            rr_d = WMAX;
            ov_d = 1'b1;
          end else begin
            rr_d = root_inc[WORD_BITS-1:0];
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_re_d    = dz_q ? '0 : rr_q;
          out_im_d    = dz_q ? '0 : ri_q;
          out_st_d    = dz_q ? ST_DIV0 : (ov_q ? ST_OVF : ST_OK);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    mac_q    <= mac_d;
    step_q   <= step_d;
    xr_q     <= xr_d;
    xi_q     <= xi_d;
    yr_q     <= yr_d;
    yi_q     <= yi_d;
    acc0_q   <= acc0_d;
    acc1_q   <= acc1_d;
    den_q    <= den_d;
    cnt_q    <= cnt_d;
    eneg_q   <= eneg_d;
    ov_q     <= ov_d;
    dz_q     <= dz_d;
    rr_q     <= rr_d;
    ri_q     <= ri_d;
    neg_q    <= neg_d;
    out_re_q <= out_re_d;
    out_im_q <= out_im_d;
    out_st_q <= out_st_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_real_o  = out_re_q;
  assign res_imag_o  = out_im_q;
  assign status_o    = out_st_q;

  `CFPA_ASSERT_IMP(a_idle_units, in_ready_o, !div_stat.busy && !sqrt_stat.busy,
                   "arithmetic unit busy while accepting a beat")
  `CFPA_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready_o,
                   "ready stayed high after a beat was accepted")
  `CFPA_ASSERT_IMP(a_div0_zero, out_valid_o && (status_o == ST_DIV0),
                   (res_real_o == '0) && (res_imag_o == '0),
                   "divide-by-zero result is not zero")
  `CFPA_ASSERT_IMP(a_div_done_state, div_stat.done,
                   (state_q == S_DIVRE) || (state_q == S_DIVIM),
                   "divider finished outside a division state")

endmodule

// ===== bench/complex_fixed_point_alu_tb.sv =====
`timescale 1ns / 1ps

module complex_fixed_point_alu_tb;
  import cfpa_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [OP_BITS-1:0]          op;
    logic signed [WORD_BITS-1:0] ar;
    logic signed [WORD_BITS-1:0] ai;
    logic signed [WORD_BITS-1:0] br;
    logic signed [WORD_BITS-1:0] bi;
    logic signed [EXP_BITS-1:0]  ex;
  } alu_beat_t;

  typedef struct {
    logic signed [WORD_BITS-1:0] re;
    logic signed [WORD_BITS-1:0] im;
    logic [ST_BITS-1:0]          st;
  } alu_result_t;

  // Expected results of the complex ALU, in acceptance order, and the checks
  // against what the block returns. The arithmetic uses 128-bit signed
  // intermediates, so every product sum and scaled numerator stays exact.
  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function logic signed [WORD_BITS-1:0] clamp_word(wide_t v, inout bit ov);
      wide_t hi_lim;
      wide_t lo_lim;
      hi_lim = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v < lo_lim) begin
        ov = 1'b1;
        return lo_lim[WORD_BITS-1:0];
      end
      if (v > hi_lim) begin
        ov = 1'b1;
        return hi_lim[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
    endfunction

    // Round half up, drop the extra fraction bits of a product sum, then clamp.
    function logic signed [WORD_BITS-1:0] round_prod(wide_t v, inout bit ov);
      return clamp_word((v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS, ov);
    endfunction

    // Quotient rounded on its magnitude; the sign is put back afterwards.
    function logic signed [WORD_BITS-1:0] round_quot(wide_t n, wide_t d, inout bit ov);
      logic [127:0] mag;
      logic [127:0] q;
      bit           neg;
      neg = n < 0;
      mag = neg ? -n : n;
      mag = (mag << FRAC_BITS) + (d >> 1);
      q = mag / d;
      if (neg) q = -q;
      return clamp_word(signed'(q), ov);
    endfunction

    function void cplx_mul(input logic signed [WORD_BITS-1:0] ar, ai, br, bi,
                           output logic signed [WORD_BITS-1:0] rr, ri, inout bit ov);
      wide_t re;
      wide_t im;
      re = wide_t'(ar) * wide_t'(br) - wide_t'(ai) * wide_t'(bi);
      im = wide_t'(ar) * wide_t'(bi) + wide_t'(ai) * wide_t'(br);
      rr = round_prod(re, ov);
      ri = round_prod(im, ov);
    endfunction

    // Returns 0 when the divisor is zero.
    function bit cplx_div(input logic signed [WORD_BITS-1:0] ar, ai, br, bi,
                          output logic signed [WORD_BITS-1:0] rr, ri, inout bit ov);
      wide_t den;
      wide_t nr;
      wide_t ni;
      rr = '0;
      ri = '0;
      den = wide_t'(br) * wide_t'(br) + wide_t'(bi) * wide_t'(bi);
      if (den == 0) return 1'b0;
      nr = wide_t'(ar) * wide_t'(br) + wide_t'(ai) * wide_t'(bi);
      ni = wide_t'(ai) * wide_t'(br) - wide_t'(ar) * wide_t'(bi);
      rr = round_quot(nr, den, ov);
      ri = round_quot(ni, den, ov);
      return 1'b1;
    endfunction

    function alu_result_t alu_outcome(alu_beat_t b);
      alu_result_t                 r;
      bit                          ov;
      bit                          dz;
      int                          e;
      int                          n;
      logic signed [WORD_BITS-1:0] pr;
      logic signed [WORD_BITS-1:0] pi;
      wide_t                       sum;
      logic [63:0]                 root;
      logic [63:0]                 cand;
      ov = 1'b0;
      dz = 1'b0;
      r.re = '0;
      r.im = '0;
      case (b.op)
        OP_ADD: begin
          r.re = clamp_word(wide_t'(b.ar) + wide_t'(b.br), ov);
          r.im = clamp_word(wide_t'(b.ai) + wide_t'(b.bi), ov);
        end
        OP_SUB: begin
          r.re = clamp_word(wide_t'(b.ar) - wide_t'(b.br), ov);
          r.im = clamp_word(wide_t'(b.ai) - wide_t'(b.bi), ov);
        end
        OP_MUL: cplx_mul(b.ar, b.ai, b.br, b.bi, r.re, r.im, ov);
        OP_DIV: dz = !cplx_div(b.ar, b.ai, b.br, b.bi, r.re, r.im, ov);
        OP_POW: begin
          e = int'(b.ex);
          if (e > MAX_EXP) e = MAX_EXP;
          if (e < -MAX_EXP) e = -MAX_EXP;
          n = e < 0 ? -e : e;
          pr = ONE_Q;
          pi = '0;
          for (int k = 0; k < n; k++) cplx_mul(pr, pi, b.ar, b.ai, pr, pi, ov);
          if (e < 0) begin
            dz = !cplx_div(ONE_Q, '0, pr, pi, r.re, r.im, ov);
          end else begin
            r.re = pr;
            r.im = pi;
          end
        end
        OP_MOD: begin
          sum = wide_t'(b.ar) * wide_t'(b.ar) + wide_t'(b.ai) * wide_t'(b.ai);
          root = '0;
          for (int k = 62; k >= 0; k--) begin
            cand = root | (64'd1 << k);
            if (wide_t'({64'd0, cand}) * wide_t'({64'd0, cand}) <= sum) root = cand;
          end
          if (wide_t'({64'd0, root}) * wide_t'({64'd0, root}) + wide_t'({64'd0, root}) < sum)
            root++;
          r.re = clamp_word(wide_t'({64'd0, root}), ov);
          r.im = '0;
        end
        default: ;
      endcase
      if (dz) begin
        r.re = '0;
        r.im = '0;
      end
      r.st = dz ? ST_DIV0 : (ov ? ST_OVF : ST_OK);
      return r;
    endfunction

    function void note_beat(alu_beat_t b);
      pending.push_back(alu_outcome(b));
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: re=%0d im=%0d status=%0d",
               got.re, got.im, got.st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re) begin
        $error("res_real: expected %0d, got %0d", want.re, got.re);
        errors++;
      end
      if (got.im !== want.im) begin
        $error("res_imag: expected %0d, got %0d", want.im, got.im);
        errors++;
      end
      if (got.st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, got.st);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 400;
  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [OP_BITS-1:0]          opcode_i;
  logic signed [WORD_BITS-1:0] a_real_i;
  logic signed [WORD_BITS-1:0] a_imag_i;
  logic signed [WORD_BITS-1:0] b_real_i;
  logic signed [WORD_BITS-1:0] b_imag_i;
  logic signed [EXP_BITS-1:0]  exponent_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [WORD_BITS-1:0] res_real_o;
  logic signed [WORD_BITS-1:0] res_imag_o;
  logic [ST_BITS-1:0]          status_o;

  alu_scoreboard sb;
  int            snd_idle_pct;
  int            rcv_idle_pct;
  bit            hold_request;
  int            cycle_count;

  complex_fixed_point_alu i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .a_real_i    (a_real_i),
    .a_imag_i    (a_imag_i),
    .b_real_i    (b_real_i),
    .b_imag_i    (b_imag_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_real_o  (res_real_o),
    .res_imag_o  (res_imag_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. The slowest legal run is roughly 430 negative powers plus
  // idling and receiver stalls, far below this limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver side. Ready changes on the falling edge only. A hold request
  // keeps ready low for a long stretch so the finished result sits in the
  // output register and the block then stalls its input.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = $urandom_range(0, 99) >= rcv_idle_pct;
      end
    end
  end

  // Every result beat is checked at the rising edge where it is taken.
  always @(posedge clk_i) begin
    alu_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.re = res_real_o;
      got.im = res_imag_o;
      got.st = status_o;
      sb.check_result(got);
    end
  end

  // Offers one beat. The task is entered just after a falling edge and
  // returns just after the falling edge that follows acceptance, so valid
  // and payload get at most one assignment per falling edge.
  task automatic send_beat(alu_beat_t b);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i   = b.op;
    a_real_i   = b.ar;
    a_imag_i   = b.ai;
    b_real_i   = b.br;
    b_imag_i   = b.bi;
    exponent_i = b.ex;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_beat(b);
    @(negedge clk_i);
  endtask

  // The sender pauses until every expected result is back, then leaves
  // time for anything still in flight to show up.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  function automatic alu_beat_t make_beat(logic [OP_BITS-1:0] op,
                                          logic signed [WORD_BITS-1:0] ar, ai, br, bi,
                                          logic signed [EXP_BITS-1:0] ex);
    alu_beat_t b;
    b.op = op;
    b.ar = ar;
    b.ai = ai;
    b.br = br;
    b.bi = bi;
    b.ex = ex;
    return b;
  endfunction

  // Operand mix: full-range words, values within two units so powers and
  // products stay in range, values near one, the extremes, and zero.
  function automatic logic signed [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5, 6: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      7: return $urandom_range(0, 1) ? W_MAX : W_MIN;
      8: return '0;
      default: return $signed($urandom_range(0, 32'h0000_4000)) + 32'sh0000_E000;
    endcase
  endfunction

  function automatic alu_beat_t random_beat();
    alu_beat_t b;
    int        sel;
    sel = $urandom_range(0, 99);
    if (sel < 94) b.op = OP_BITS'($urandom_range(OP_ADD, OP_MOD));
    else b.op = OP_BITS'($urandom_range(6, 7));
    b.ar = pick_word();
    b.ai = pick_word();
    b.br = pick_word();
    b.bi = pick_word();
    // Divisor of zero now and then.
    if (b.op == OP_DIV && $urandom_range(0, 15) == 0) begin
      b.br = '0;
      b.bi = '0;
    end
    if ($urandom_range(0, 7) == 0) b.ex = EXP_BITS'($urandom);
    else b.ex = EXP_BITS'($signed($urandom_range(0, 2 * MAX_EXP)) - MAX_EXP);
    return b;
  endfunction

  localparam logic signed [WORD_BITS-1:0] TWO_Q  = 32'sh0002_0000;
  localparam logic signed [WORD_BITS-1:0] HALF_Q = 32'sh0000_8000;

  initial begin
    sb = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_ADD;
    a_real_i     = '0;
    a_imag_i     = '0;
    b_real_i     = '0;
    b_imag_i     = '0;
    exponent_i   = '0;
    hold_request = 1'b0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats: saturation on every operation, divide by zero, the
    // power corner cases, the rounding of the modulus and the unused opcodes.
    send_beat(make_beat(OP_ADD, W_MAX, W_MIN, W_MAX, W_MIN, '0));
    send_beat(make_beat(OP_ADD, ONE_Q, -ONE_Q, HALF_Q, TWO_Q, '0));
    send_beat(make_beat(OP_SUB, W_MIN, W_MAX, W_MAX, W_MIN, '0));
    send_beat(make_beat(OP_SUB, TWO_Q, HALF_Q, ONE_Q, -ONE_Q, '0));
    send_beat(make_beat(OP_MUL, TWO_Q, ONE_Q, -HALF_Q, TWO_Q, '0));
    send_beat(make_beat(OP_MUL, W_MIN, W_MIN, W_MIN, W_MAX, '0));
    send_beat(make_beat(OP_MUL, 32'sd1, 32'sd1, 32'sd1, -32'sd1, '0));
    send_beat(make_beat(OP_DIV, ONE_Q, TWO_Q, '0, '0, '0));
    send_beat(make_beat(OP_DIV, ONE_Q, '0, TWO_Q, ONE_Q, '0));
    send_beat(make_beat(OP_DIV, W_MAX, W_MIN, 32'sd1, '0, '0));
    send_beat(make_beat(OP_DIV, -ONE_Q, 32'sd3, 32'sd3, -32'sd7, '0));
    send_beat(make_beat(OP_POW, TWO_Q, ONE_Q, '0, '0, 6'sd0));
    send_beat(make_beat(OP_POW, ONE_Q, ONE_Q, '0, '0, 6'sd16));
    send_beat(make_beat(OP_POW, TWO_Q, '0, '0, '0, 6'sd31));
    send_beat(make_beat(OP_POW, TWO_Q, HALF_Q, '0, '0, -6'sd16));
    send_beat(make_beat(OP_POW, TWO_Q, '0, '0, '0, -6'sd32));
    send_beat(make_beat(OP_POW, '0, '0, '0, '0, -6'sd3));
    send_beat(make_beat(OP_POW, W_MAX, W_MAX, '0, '0, -6'sd2));
    send_beat(make_beat(OP_MOD, 32'sd3, 32'sd4, '0, '0, '0));
    send_beat(make_beat(OP_MOD, 32'sd1, 32'sd1, '0, '0, '0));
    send_beat(make_beat(OP_MOD, W_MIN, W_MIN, '0, '0, '0));
    send_beat(make_beat(OP_MOD, W_MAX, '0, '0, '0, '0));
    send_beat(make_beat(3'd6, W_MAX, W_MIN, ONE_Q, ONE_Q, 6'sd5));
    send_beat(make_beat(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -6'sd1));
    drain_results();

    // Random beats in three phases, two of them with idling. The first parks the
    // receiver for a long stretch while the sender keeps offering beats.
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = phase == 0 ? 15 : (phase == 1 ? 47 : 0);
      rcv_idle_pct = phase == 0 ? 47 : (phase == 1 ? 15 : 0);
      for (int n = 0; n < 134; n++) begin
        if (phase == 0 && n == 40) hold_request = 1'b1;
        send_beat(random_beat());
      end
      drain_results();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== complex_fixed_point_alu.f =====
+incdir+hw/rtl
hw/rtl/cfpa_pkg.sv
hw/rtl/cfpa_mul.sv
hw/rtl/cfpa_div.sv
hw/rtl/cfpa_sqrt.sv
hw/rtl/complex_fixed_point_alu.sv
bench/complex_fixed_point_alu_tb.sv
